// ===== design/periodic_task_tick_scheduler_top_defines.svh =====
// Assertion macros for the periodic task tick scheduler checker.
// Uses the aclk / aresetn names of the top level ports; no other dependencies.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PTTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ptts: same-cycle check failed");

// next-cycle implication, disabled in reset
`define PTTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ptts: next-cycle check failed");

`endif

// ===== design/ptts_pkg.sv =====
// Package for the periodic task tick scheduler: sizes, command codes,
// state and result types. No dependencies.
`timescale 1ns / 1ps

package ptts_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int COUNT_WIDTH = 16;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int LEN_W = $clog2(NUM_SLOTS + 1);

    localparam int CMD_W       = 3;
    localparam int SLOT_W      = 4;
    localparam int PERIOD_W    = 16;
    localparam int CNT_OUT_W   = 5;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_SERVICE = 3'd1,
        CMD_ADD     = 3'd2,
        CMD_DELETE  = 3'd3,
        CMD_INIT    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [SLOT_W-1:0]      slot;
        logic                   has_task;
        logic                   status;
        logic [COUNT_WIDTH-1:0] period;
        logic                   last;
    } result_t;

endpackage

// ===== design/periodic_task_tick_scheduler_top.sv =====
// Periodic task tick scheduler, top level. Uses ptts_pkg for sizes,
// command codes and types.
`timescale 1ns / 1ps

// A bank of per-slot countdown timers kept in an ordered active list. Tick,
// service and delete walk the active list one entry per cycle (a service walk
// stalls while its held result has no place to go) through a single shared
// decrement/compare unit; add, init, out-of-range slots and unknown commands
// skip the walk. No new item is accepted before the current one is finished.
// Any item also holds in its last cycle while the output register still has
// an earlier result not yet taken, and service waits for each of its results
// to be taken beyond the one held in the output register. Every item yields
// one result, except service, which yields one result per pending slot (in
// insertion order, the final one with tlast) or one empty result.
module periodic_task_tick_scheduler_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ptts_pkg::S_TDATA_W-1:0]   s_tdata,  // slot[3:0], period_value[19:4], reload_now[20]
    input  logic [ptts_pkg::CMD_W-1:0]       s_tuser,  // cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ptts_pkg::M_TDATA_W-1:0]   m_tdata,  // slot_out[3:0], status[4], active_count[9:5],
                                                       // deleted_count[14:10], period_out[30:15]
    output logic [0:0]                       m_tuser,  // has_task
    output logic                             m_tlast   // last
);

    localparam int NS  = ptts_pkg::NUM_SLOTS;
    localparam int CW  = ptts_pkg::COUNT_WIDTH;
    localparam int IW  = ptts_pkg::IDX_W;
    localparam int LW  = ptts_pkg::LEN_W;

    // input fields
    logic [ptts_pkg::SLOT_W-1:0]   in_slot;
    logic [ptts_pkg::PERIOD_W-1:0] in_period;
    logic                          in_reload;
    assign in_slot   = s_tdata[3:0];
    assign in_period = s_tdata[19:4];
    assign in_reload = s_tdata[20];

    ptts_pkg::state_t state_reg, state_next;

    logic [ptts_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ptts_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [CW-1:0]               pv_reg, pv_next;
    logic                        rl_reg, rl_next;
    logic                        ign_reg, ign_next;
    logic [LW-1:0]               idx_reg, idx_next;
    logic [LW-1:0]               wr_reg, wr_next;

    logic                        hold_valid_reg, hold_valid_next;
    logic [IW-1:0]               hold_slot_reg, hold_slot_next;
    logic [CW-1:0]               hold_period_reg, hold_period_next;

    logic [CW-1:0]               countdown_reg [NS];
    logic [CW-1:0]               period_reg [NS];
    logic [NS-1:0]               pending_reg;
    logic [IW-1:0]               order_reg [NS];
    logic [LW-1:0]               active_len_reg, active_len_next;
    logic [NS-1:0]               active_mask_reg, active_mask_next;
    logic [NS-1:0]               deleted_mask_reg, deleted_mask_next;
    logic [LW-1:0]               del_cnt_reg, del_cnt_next;

    logic                          m_valid_reg, m_valid_next;
    logic [ptts_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                          m_user_reg, m_user_next;
    logic                          m_last_reg, m_last_next;

    // slot table write port (shared address with the read side)
    logic          cd_we, per_we, pend_we, pend_wdata;
    logic [CW-1:0] cd_wdata;
    logic          order_we;
    logic [IW-1:0] order_waddr, order_wdata;

    logic               push;
    ptts_pkg::result_t  res;

    // decode
    logic          acc, in_ign, start_walk;
    logic [IW-1:0] walk_slot, cur_slot, addr;
    logic          walk_end, out_free, svc_stall;
    logic [CW-1:0] cd_rd, per_rd, cd_dec;
    logic          pend_rd, act_hit, del_hit;

    assign acc = s_tvalid && s_tready;

    assign in_ign = (s_tuser > ptts_pkg::CMD_INIT) ||
                    (((s_tuser == ptts_pkg::CMD_ADD) || (s_tuser == ptts_pkg::CMD_DELETE) ||
                      (s_tuser == ptts_pkg::CMD_INIT)) && (32'(in_slot) >= 32'(NS)));
    assign start_walk = !in_ign && ((s_tuser == ptts_pkg::CMD_TICK) ||
                                    (s_tuser == ptts_pkg::CMD_SERVICE) ||
                                    (s_tuser == ptts_pkg::CMD_DELETE));

    assign walk_slot = order_reg[idx_reg[IW-1:0]];
    assign cur_slot  = IW'(slot_reg);
    assign addr      = (state_reg == ptts_pkg::ST_WALK) ? walk_slot : cur_slot;
    assign walk_end  = (idx_reg == active_len_reg);
    assign out_free  = !m_valid_reg || m_tready;

    assign cd_rd   = countdown_reg[addr];
    assign per_rd  = period_reg[addr];
    assign pend_rd = pending_reg[addr];
    assign cd_dec  = cd_rd - CW'(1);
    assign act_hit = active_mask_reg[cur_slot];
    assign del_hit = deleted_mask_reg[cur_slot];

    // a new pending slot can only be taken once the held one has a place to go
    assign svc_stall = (state_reg == ptts_pkg::ST_WALK) && (cmd_reg == ptts_pkg::CMD_SERVICE) &&
                       !walk_end && pend_rd && hold_valid_reg && !out_free;

    assign s_tready = (state_reg == ptts_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptts_pkg::ST_IDLE: begin
                if (acc) begin
                    state_next = start_walk ? ptts_pkg::ST_WALK : ptts_pkg::ST_FINISH;
                end
            end
            ptts_pkg::ST_WALK: begin
                if (walk_end) begin
                    state_next = ptts_pkg::ST_FINISH;
                end
            end
            ptts_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = ptts_pkg::ST_IDLE;
                end
            end
            default: state_next = ptts_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cmd_next          = cmd_reg;
        slot_next         = slot_reg;
        pv_next           = pv_reg;
        rl_next           = rl_reg;
        ign_next          = ign_reg;
        idx_next          = idx_reg;
        wr_next           = wr_reg;
        hold_valid_next   = hold_valid_reg;
        hold_slot_next    = hold_slot_reg;
        hold_period_next  = hold_period_reg;
        active_len_next   = active_len_reg;
        active_mask_next  = active_mask_reg;
        deleted_mask_next = deleted_mask_reg;
        del_cnt_next      = del_cnt_reg;
        cd_we             = 1'b0;
        cd_wdata          = cd_dec;
        per_we            = 1'b0;
        pend_we           = 1'b0;
        pend_wdata        = 1'b0;
        order_we          = 1'b0;
        order_waddr       = wr_reg[IW-1:0];
        order_wdata       = walk_slot;
        push              = 1'b0;
        res               = '0;

        unique case (state_reg)
            ptts_pkg::ST_IDLE: begin
                if (acc) begin
                    cmd_next  = s_tuser;
                    slot_next = in_slot;
                    pv_next   = CW'(in_period);
                    rl_next   = in_reload;
                    ign_next  = in_ign;
                    idx_next  = '0;
                    wr_next   = '0;
                end
            end
            ptts_pkg::ST_WALK: begin
                if (!walk_end && !svc_stall) begin
                    idx_next = idx_reg + LW'(1);
                end
                unique case (cmd_reg)
                    ptts_pkg::CMD_TICK: begin
                        if (!walk_end && (cd_rd != '0)) begin
                            cd_we = 1'b1;
                            if (cd_dec == '0) begin
                                cd_wdata   = per_rd;
                                pend_we    = 1'b1;
                                pend_wdata = 1'b1;
                            end
                        end
                    end
                    ptts_pkg::CMD_SERVICE: begin
                        if (!walk_end && pend_rd && !svc_stall) begin
                            pend_we = 1'b1;
                            if (hold_valid_reg) begin
                                push         = 1'b1;
                                res.slot     = ptts_pkg::SLOT_W'(hold_slot_reg);
                                res.has_task = 1'b1;
                                res.period   = hold_period_reg;
                            end
                            hold_valid_next  = 1'b1;
                            hold_slot_next   = walk_slot;
                            hold_period_next = per_rd;
                        end
                    end
                    ptts_pkg::CMD_DELETE: begin
                        // compact the list, dropping the deleted slot
                        if (!walk_end && (walk_slot != cur_slot)) begin
                            order_we = 1'b1;
                            wr_next  = wr_reg + LW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            ptts_pkg::ST_FINISH: begin
                if (out_free) begin
                    push     = 1'b1;
                    res.last = 1'b1;
                    if (ign_reg) begin
                        res.slot = (cmd_reg > ptts_pkg::CMD_INIT) ? '0 : slot_reg;
                    end else begin
                        unique case (cmd_reg)
                            ptts_pkg::CMD_SERVICE: begin
                                if (hold_valid_reg) begin
                                    res.slot        = ptts_pkg::SLOT_W'(hold_slot_reg);
                                    res.has_task    = 1'b1;
                                    res.period      = hold_period_reg;
                                    hold_valid_next = 1'b0;
                                end
                            end
                            ptts_pkg::CMD_ADD: begin
                                res.slot   = slot_reg;
                                res.period = per_rd;
                                if (del_hit) begin
                                    pend_we                     = 1'b1;
                                    deleted_mask_next[cur_slot] = 1'b0;
                                    del_cnt_next                = del_cnt_reg - LW'(1);
                                end
                                if (act_hit) begin
                                    res.status = 1'b1;
                                end else begin
                                    if (32'(active_len_reg) < 32'(NS)) begin
                                        order_we        = 1'b1;
                                        order_waddr     = active_len_reg[IW-1:0];
                                        order_wdata     = cur_slot;
                                        active_len_next = active_len_reg + LW'(1);
                                    end
                                    active_mask_next[cur_slot] = 1'b1;
                                end
                            end
                            ptts_pkg::CMD_DELETE: begin
                                res.slot   = slot_reg;
                                res.period = per_rd;
                                if (act_hit) begin
                                    pend_we                    = 1'b1;
                                    active_mask_next[cur_slot] = 1'b0;
                                    active_len_next            = wr_reg;
                                end
                                if (del_hit) begin
                                    res.status = 1'b1;
                                end else begin
                                    deleted_mask_next[cur_slot] = 1'b1;
                                    del_cnt_next                = del_cnt_reg + LW'(1);
                                end
                            end
                            ptts_pkg::CMD_INIT: begin
                                res.slot   = slot_reg;
                                res.period = pv_reg;
                                per_we     = 1'b1;
                                if (rl_reg) begin
                                    cd_we    = 1'b1;
                                    cd_wdata = pv_reg;
                                    pend_we  = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase

        m_data_next = m_data_reg;
        m_user_next = m_user_reg;
        m_last_next = m_last_reg;
        if (push) begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, ptts_pkg::PERIOD_W'(res.period),
                            ptts_pkg::CNT_OUT_W'(del_cnt_next),
                            ptts_pkg::CNT_OUT_W'(active_len_next),
                            res.status, res.slot};
            m_user_next  = res.has_task;
            m_last_next  = res.last;
        end else begin
            m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ptts_pkg::ST_IDLE;
            idx_reg          <= '0;
            wr_reg           <= '0;
            hold_valid_reg   <= 1'b0;
            pending_reg      <= '0;
            active_len_reg   <= '0;
            active_mask_reg  <= '0;
            deleted_mask_reg <= '0;
            del_cnt_reg      <= '0;
            m_valid_reg      <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                countdown_reg[i] <= '0;
                period_reg[i]    <= '0;
            end
        end else begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            wr_reg           <= wr_next;
            hold_valid_reg   <= hold_valid_next;
            active_len_reg   <= active_len_next;
            active_mask_reg  <= active_mask_next;
            deleted_mask_reg <= deleted_mask_next;
            del_cnt_reg      <= del_cnt_next;
            m_valid_reg      <= m_valid_next;
            if (pend_we) begin
                pending_reg[addr] <= pend_wdata;
            end
            if (cd_we) begin
                countdown_reg[addr] <= cd_wdata;
            end
            if (per_we) begin
                period_reg[addr] <= pv_reg;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        slot_reg        <= slot_next;
        pv_reg          <= pv_next;
        rl_reg          <= rl_next;
        ign_reg         <= ign_next;
        hold_slot_reg   <= hold_slot_next;
        hold_period_reg <= hold_period_next;
        m_data_reg      <= m_data_next;
        m_user_reg      <= m_user_next;
        m_last_reg      <= m_last_next;
        if (order_we) begin
            order_reg[order_waddr] <= order_wdata;
        end
    end

endmodule

// ===== design/ptts_checker.sv =====
// Port-level checker for the periodic task tick scheduler, bound to the top.
// Uses ptts_pkg for port widths and the assertion macros header.
`timescale 1ns / 1ps
`include "periodic_task_tick_scheduler_top_defines.svh"

module ptts_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ptts_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser,
    input logic                           m_tlast
);

    // stalled result holds
    `PTTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // the block is busy in the cycle after it accepts an item
    `PTTS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // while a service run is still emitting, no new item is taken
    `PTTS_ASSERT_SAME(a_no_accept_mid_run, m_tvalid && !m_tlast, !s_tready)

    // a served slot comes from a nonempty active list and reports done
    `PTTS_ASSERT_SAME(a_served_ok, m_tvalid && m_tuser[0], !m_tdata[4] && (m_tdata[9:5] != 5'd0))

endmodule

bind periodic_task_tick_scheduler_top ptts_checker u_ptts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
